[hdl/euler_rotate_acceleration_defines.svh]
// Assertion macros for the Euler acceleration rotation block.
// Used by the top level; no other dependencies.
`ifndef EULER_ROTATE_ACCELERATION_DEFINES_SVH
`define EULER_ROTATE_ACCELERATION_DEFINES_SVH
`ifndef SYNTHESIS
`define ERA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ERA_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);
`else
`define ERA_ASSERT(label, clk, rst_n, prop, msg)
`define ERA_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg)
`endif
`endif

[hdl/era_pkg.sv]
// Package for the Euler acceleration rotation block: widths, CORDIC constants
// and the arctangent table. No dependencies.
`default_nettype none
package era_pkg;
    localparam int ANGLE_WIDTH_DEF = 16;
    localparam int ACCEL_WIDTH_DEF = 20;
    localparam int TRIG_STAGES_DEF = 16;
    localparam int TAG_WIDTH = 32;
    localparam int TRIG_WIDTH = 34;
    localparam int ZW = 36;
    localparam logic signed [ZW-1:0] Q30_PI = 36'sd3373259426;
    localparam logic signed [ZW-1:0] Q30_HALF_PI = 36'sd1686629713;
    localparam logic signed [TRIG_WIDTH-1:0] CORDIC_GAIN = 34'sd652032874;

    function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
        logic signed [ZW-1:0] r;
        unique case (i)
            5'd0: r = 36'sh03243F6A8;
            5'd1: r = 36'sh01DAC6705;
            5'd2: r = 36'sh00FADBAFC;
            5'd3: r = 36'sh007F56EA6;
            5'd4: r = 36'sh003FEAB76;
            5'd5: r = 36'sh001FFD55B;
            5'd6: r = 36'sh000FFFAAA;
            5'd7: r = 36'sh0007FFF55;
            5'd8: r = 36'sh0003FFFEA;
            5'd9: r = 36'sh0001FFFFD;
            5'd10: r = 36'sh0000FFFFF;
            5'd11: r = 36'sh00007FFFF;
            5'd12: r = 36'sh00003FFFF;
            5'd13: r = 36'sh00001FFFF;
            5'd14: r = 36'sh00000FFFF;
            5'd15: r = 36'sh000007FFF;
            5'd16: r = 36'sh000003FFF;
            5'd17: r = 36'sh000001FFF;
            5'd18: r = 36'sh000000FFF;
            5'd19: r = 36'sh0000007FF;
            5'd20: r = 36'sh0000003FF;
            5'd21: r = 36'sh0000001FF;
            5'd22: r = 36'sh0000000FF;
            5'd23: r = 36'sh00000007F;
            default: r = '0;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

[hdl/era_if.sv]
// Valid/ready channel interfaces for IMU samples and rotated results.
// No dependencies.
`default_nettype none
interface era_in_if #(parameter int ANGLE_WIDTH = 16, parameter int ACCEL_WIDTH = 20);
    logic valid;
    logic ready;
    logic signed [ANGLE_WIDTH-1:0] roll_in;
    logic signed [ANGLE_WIDTH-1:0] pitch_in;
    logic signed [ANGLE_WIDTH-1:0] yaw_in;
    logic signed [ACCEL_WIDTH-1:0] accel_x_in;
    logic signed [ACCEL_WIDTH-1:0] accel_y_in;
    logic signed [ACCEL_WIDTH-1:0] accel_z_in;
    logic [31:0] sample_tag;
    modport source (output valid, roll_in, pitch_in, yaw_in, accel_x_in, accel_y_in,
        accel_z_in, sample_tag, input ready);
    modport sink (input valid, roll_in, pitch_in, yaw_in, accel_x_in, accel_y_in,
        accel_z_in, sample_tag, output ready);
endinterface

interface era_out_if #(parameter int ANGLE_WIDTH = 16, parameter int ACCEL_WIDTH = 20);
    logic valid;
    logic ready;
    logic signed [ANGLE_WIDTH-1:0] roll_out;
    logic signed [ANGLE_WIDTH-1:0] pitch_out;
    logic signed [ANGLE_WIDTH-1:0] yaw_out;
    logic signed [ACCEL_WIDTH+1:0] rotated_x;
    logic signed [ACCEL_WIDTH+1:0] rotated_y;
    logic signed [ACCEL_WIDTH+1:0] rotated_z;
    logic [31:0] tag_out;
    modport source (output valid, roll_out, pitch_out, yaw_out, rotated_x, rotated_y,
        rotated_z, tag_out, input ready);
    modport sink (input valid, roll_out, pitch_out, yaw_out, rotated_x, rotated_y,
        rotated_z, tag_out, output ready);
endinterface
`default_nettype wire

[hdl/era_cordic.sv]
// Pipelined CORDIC sine/cosine of one Q3.x angle, one stage per iteration.
// Depends on era_pkg. Advances only on en.
`default_nettype none
module era_cordic
    import era_pkg::*;
#(
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
    parameter int TRIG_STAGES = TRIG_STAGES_DEF
)(
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic signed [ANGLE_WIDTH-1:0] angle,
    output logic signed [TRIG_WIDTH-1:0]       sin_q30,
    output logic signed [TRIG_WIDTH-1:0]       cos_q30
);
    localparam int N = (TRIG_STAGES < 24) ? TRIG_STAGES : 24;

    logic signed [ZW-1:0]         z_reg [0:N];
    logic signed [TRIG_WIDTH-1:0] x_reg [0:N];
    logic signed [TRIG_WIDTH-1:0] y_reg [0:N];
    logic                         neg_reg [0:N];

    logic signed [ZW-1:0] z0;
    logic signed [ZW-1:0] z0_next;
    logic                 neg_next;

    always_comb
    begin
        z0 = ZW'(angle) <<< (33 - ANGLE_WIDTH);
        z0_next = z0;
        neg_next = 1'b0;
        if (z0 > Q30_HALF_PI)
        begin
            z0_next = z0 - Q30_PI;
            neg_next = 1'b1;
        end
        else if (z0 < -Q30_HALF_PI)
        begin
            z0_next = z0 + Q30_PI;
            neg_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_reg[0] <= z0_next;
            x_reg[0] <= CORDIC_GAIN;
            y_reg[0] <= '0;
            neg_reg[0] <= neg_next;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        logic signed [TRIG_WIDTH-1:0] dx;
        logic signed [TRIG_WIDTH-1:0] dy;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg_reg[i+1] <= neg_reg[i];
                if (!z_reg[i][ZW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - atan_q30(5'(i));
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + atan_q30(5'(i));
                end
            end
        end
    end

    assign sin_q30 = neg_reg[N] ? -y_reg[N] : y_reg[N];
    assign cos_q30 = neg_reg[N] ? -x_reg[N] : x_reg[N];
endmodule
`default_nettype wire

[hdl/euler_rotate_acceleration.sv]
// Top level of the Euler acceleration rotation block.
// Depends on era_pkg, era_if, era_cordic and the assertion macro header.
//
// Takes one IMU sample per cycle when not stalled and returns one rotated
// sample for each. The CORDIC stages for sine and cosine are followed by six
// stages: two of trig products, then coefficient sums, accel products, row
// sums and the saturated output register. The whole pipeline advances as one
// when the output register is free or taken, so an output stall holds all.
`include "euler_rotate_acceleration_defines.svh"
`default_nettype none
module euler_rotate_acceleration
    import era_pkg::*;
#(
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
    parameter int ACCEL_WIDTH = ACCEL_WIDTH_DEF,
    parameter int TRIG_STAGES = TRIG_STAGES_DEF
)(
    input  wire logic clk,
    input  wire logic rst_n,
    era_in_if.sink    sample,
    era_out_if.source result
);
    localparam int N = (TRIG_STAGES < 24) ? TRIG_STAGES : 24;
    localparam int LAT = N + 6;
    localparam int TW = TRIG_WIDTH;
    localparam int OW = ACCEL_WIDTH + 2;
    localparam int AW = ACCEL_WIDTH + 4;

    typedef struct packed {
        logic signed [ANGLE_WIDTH-1:0] roll;
        logic signed [ANGLE_WIDTH-1:0] pitch;
        logic signed [ANGLE_WIDTH-1:0] yaw;
        logic signed [ACCEL_WIDTH-1:0] ax;
        logic signed [ACCEL_WIDTH-1:0] ay;
        logic signed [ACCEL_WIDTH-1:0] az;
        logic [TAG_WIDTH-1:0]          tag;
    } side_t;

    function automatic logic signed [TW-1:0] m30(input logic signed [TW-1:0] a,
                                                 input logic signed [TW-1:0] b);
        logic signed [2*TW-1:0] p;
        p = (2*TW)'(a) * (2*TW)'(b) + (2*TW)'(64'sd536870912);
        return TW'(p >>> 30);
    endfunction

    logic en;
    logic out_valid_reg;
    logic [LAT-1:0] valid_reg;
    side_t side_reg [0:LAT-1];
    side_t side_in;

    assign en = !out_valid_reg || result.ready;
    assign sample.ready = en;

    assign side_in = '{roll: sample.roll_in, pitch: sample.pitch_in, yaw: sample.yaw_in,
        ax: sample.accel_x_in, ay: sample.accel_y_in, az: sample.accel_z_in,
        tag: sample.sample_tag};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[LAT-2:0], sample.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int k = 1; k < LAT; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    logic signed [TW-1:0] sf, cf, st, ct, sp, cp;

    era_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH), .TRIG_STAGES(TRIG_STAGES)) u_roll (
        .clk(clk), .en(en), .angle(sample.roll_in), .sin_q30(sf), .cos_q30(cf));
    era_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH), .TRIG_STAGES(TRIG_STAGES)) u_yaw (
        .clk(clk), .en(en), .angle(sample.yaw_in), .sin_q30(st), .cos_q30(ct));
    era_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH), .TRIG_STAGES(TRIG_STAGES)) u_pitch (
        .clk(clk), .en(en), .angle(sample.pitch_in), .sin_q30(sp), .cos_q30(cp));

    // Stage A: trig registered, with the two roll-yaw products.
    logic signed [TW-1:0] a_sf_reg, a_cf_reg, a_st_reg, a_ct_reg, a_sp_reg, a_cp_reg;
    logic signed [TW-1:0] a_sfst_reg, a_cfst_reg;
    // Stage B: the triple and double products.
    logic signed [TW-1:0] b_p_reg [0:9];
    logic signed [TW-1:0] b_z_reg [0:2];
    // Stage C: matrix coefficients.
    logic signed [TW-1:0] c_k_reg [0:8];
    // Stage D: terms accel times coefficient.
    logic signed [AW-1:0] d_t_reg [0:8];
    // Stage E: sums.
    logic signed [AW+1:0] e_s_reg [0:2];

    side_t sd_c;
    assign sd_c = side_reg[N+3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_sf_reg <= sf; a_cf_reg <= cf; a_st_reg <= st;
            a_ct_reg <= ct; a_sp_reg <= sp; a_cp_reg <= cp;
            a_sfst_reg <= m30(sf, st);
            a_cfst_reg <= m30(cf, st);

            b_p_reg[0] <= m30(a_ct_reg, a_cp_reg);
            b_p_reg[1] <= m30(a_sfst_reg, a_cp_reg);
            b_p_reg[2] <= m30(a_cf_reg, a_sp_reg);
            b_p_reg[3] <= m30(a_sf_reg, a_sp_reg);
            b_p_reg[4] <= m30(a_cfst_reg, a_cp_reg);
            b_p_reg[5] <= m30(a_ct_reg, a_sp_reg);
            b_p_reg[6] <= m30(a_cf_reg, a_cp_reg);
            b_p_reg[7] <= m30(a_sfst_reg, a_sp_reg);
            b_p_reg[8] <= m30(a_cfst_reg, a_sp_reg);
            b_p_reg[9] <= m30(a_sf_reg, a_cp_reg);
            b_z_reg[0] <= -a_st_reg;
            b_z_reg[1] <= m30(a_sf_reg, a_ct_reg);
            b_z_reg[2] <= m30(a_cf_reg, a_ct_reg);

            c_k_reg[0] <= b_p_reg[0];
            c_k_reg[1] <= b_p_reg[1] - b_p_reg[2];
            c_k_reg[2] <= b_p_reg[3] + b_p_reg[4];
            c_k_reg[3] <= b_p_reg[5];
            c_k_reg[4] <= b_p_reg[6] + b_p_reg[7];
            c_k_reg[5] <= b_p_reg[8] - b_p_reg[9];
            c_k_reg[6] <= b_z_reg[0];
            c_k_reg[7] <= b_z_reg[1];
            c_k_reg[8] <= b_z_reg[2];

            for (int r = 0; r < 3; r++)
            begin
                d_t_reg[3*r]   <= AW'(m30(TW'(sd_c.ax), c_k_reg[3*r]));
                d_t_reg[3*r+1] <= AW'(m30(TW'(sd_c.ay), c_k_reg[3*r+1]));
                d_t_reg[3*r+2] <= AW'(m30(TW'(sd_c.az), c_k_reg[3*r+2]));
                e_s_reg[r] <= (AW+2)'(d_t_reg[3*r]) + (AW+2)'(d_t_reg[3*r+1])
                    - (AW+2)'(d_t_reg[3*r+2]);
            end
        end
    end

    function automatic logic signed [OW-1:0] sat(input logic signed [AW+1:0] v);
        logic signed [AW+1:0] hi;
        logic signed [AW+1:0] lo;
        hi = (AW+2)'({1'b0, {(OW-1){1'b1}}});
        lo = -hi - (AW+2)'(1);
        if (v > hi)
        begin
            return hi[OW-1:0];
        end
        else if (v < lo)
        begin
            return lo[OW-1:0];
        end
        return v[OW-1:0];
    endfunction

    side_t sd_o;
    assign sd_o = side_reg[LAT-1];

    logic signed [OW-1:0] rx_reg, ry_reg, rz_reg;
    side_t out_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= valid_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg <= sat(e_s_reg[0]);
            ry_reg <= sat(e_s_reg[1]);
            rz_reg <= sat(e_s_reg[2]);
            out_side_reg <= sd_o;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.roll_out = out_side_reg.roll;
    assign result.pitch_out = out_side_reg.pitch;
    assign result.yaw_out = out_side_reg.yaw;
    assign result.rotated_x = rx_reg;
    assign result.rotated_y = ry_reg;
    assign result.rotated_z = rz_reg;
    assign result.tag_out = out_side_reg.tag;

    `ERA_ASSERT_NEXT(a_stall_holds, clk, rst_n, out_valid_reg && !result.ready,
        out_valid_reg && $stable(valid_reg), "pipeline moved during a stall")
    `ERA_ASSERT_NEXT(a_valid_shift, clk, rst_n, en,
        out_valid_reg == $past(valid_reg[LAT-1]), "valid bit lost at output")
    `ERA_ASSERT(a_ready_free, clk, rst_n, !out_valid_reg |-> sample.ready,
        "input blocked with empty output")
endmodule
`default_nettype wire

[verif/euler_rotate_acceleration_tb.sv]
// Self-checking testbench for the Euler acceleration rotation block.
// Drives IMU samples over era_in_if, checks results on era_out_if against a
// bit-accurate CORDIC and Q30 product predictor. Depends on era_pkg, era_if and the top level.
`default_nettype none
module euler_rotate_acceleration_tb;
    import era_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AW = ANGLE_WIDTH_DEF;
    localparam int CW = ACCEL_WIDTH_DEF;
    localparam int NSTAGE = TRIG_STAGES_DEF;
    localparam int OW = CW + 2;
    localparam int LATENCY = NSTAGE + 7;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic signed [AW-1:0] roll;
        logic signed [AW-1:0] pitch;
        logic signed [AW-1:0] yaw;
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] az;
        logic [31:0] tag;
    } sample_t;

    typedef struct packed {
        logic signed [AW-1:0] roll;
        logic signed [AW-1:0] pitch;
        logic signed [AW-1:0] yaw;
        logic signed [OW-1:0] rx;
        logic signed [OW-1:0] ry;
        logic signed [OW-1:0] rz;
        logic [31:0] tag;
    } rotated_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int cycles = 0;
    int failures = 0;
    bit sink_idles = 1'b1;
    bit source_idles = 1'b1;
    rotated_t pending_rotations[$];

    era_in_if #(.ANGLE_WIDTH(AW), .ACCEL_WIDTH(CW)) sample_ch();
    era_out_if #(.ANGLE_WIDTH(AW), .ACCEL_WIDTH(CW)) result_ch();

    euler_rotate_acceleration dut (
        .clk(clk),
        .rst_n(rst_n),
        .sample(sample_ch.sink),
        .result(result_ch.source)
    );

    always #6 clk = ~clk;

    // Arithmetic shifts on longint floor as the datapath does.
    function automatic longint q30_mul(longint a, longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic void sin_cos(input logic signed [AW-1:0] ang,
                                    output longint s, output longint c);
        longint z, x, y, dx, dy;
        bit flip;
        z = longint'(ang) * (64'sd1 <<< (33 - AW));
        x = longint'(CORDIC_GAIN);
        y = 0;
        flip = 1'b0;
        if (z > longint'(Q30_HALF_PI)) begin
            z -= longint'(Q30_PI);
            flip = 1'b1;
        end else if (z < -longint'(Q30_HALF_PI)) begin
            z += longint'(Q30_PI);
            flip = 1'b1;
        end
        for (int i = 0; i < NSTAGE && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= longint'(atan_q30(i[4:0]));
            end else begin
                x += dx;
                y -= dy;
                z += longint'(atan_q30(i[4:0]));
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic logic signed [OW-1:0] clamp(longint v);
        longint hi, lo;
        hi = (64'sd1 <<< (OW - 1)) - 1;
        lo = -(64'sd1 <<< (OW - 1));
        if (v > hi)
            v = hi;
        if (v < lo)
            v = lo;
        return v[OW-1:0];
    endfunction

    // Roll is phi, yaw is theta, pitch is psi; the z column is negated.
    function automatic rotated_t rotate_sample(sample_t s);
        rotated_t r;
        longint sf, cf, st, ct, sp, cp, sfst, cfst, ax, ay, az;
        sin_cos(s.roll, sf, cf);
        sin_cos(s.yaw, st, ct);
        sin_cos(s.pitch, sp, cp);
        ax = s.ax;
        ay = s.ay;
        az = s.az;
        sfst = q30_mul(sf, st);
        cfst = q30_mul(cf, st);
        r.roll = s.roll;
        r.pitch = s.pitch;
        r.yaw = s.yaw;
        r.tag = s.tag;
        r.rx = clamp(q30_mul(ax, q30_mul(ct, cp))
            + q30_mul(ay, q30_mul(sfst, cp) - q30_mul(cf, sp))
            - q30_mul(az, q30_mul(sf, sp) + q30_mul(cfst, cp)));
        r.ry = clamp(q30_mul(ax, q30_mul(ct, sp))
            + q30_mul(ay, q30_mul(cf, cp) + q30_mul(sfst, sp))
            - q30_mul(az, q30_mul(cfst, sp) - q30_mul(sf, cp)));
        r.rz = clamp(q30_mul(ax, -st) + q30_mul(ay, q30_mul(sf, ct))
            - q30_mul(az, q30_mul(cf, ct)));
        return r;
    endfunction

    function automatic sample_t random_sample();
        sample_t s;
        s.roll = AW'($urandom);
        s.pitch = AW'($urandom);
        s.yaw = AW'($urandom);
        s.ax = CW'($urandom);
        s.ay = CW'($urandom);
        s.az = CW'($urandom);
        s.tag = $urandom;
        return s;
    endfunction

    initial
    begin
        sample_ch.valid = 1'b0;
        sample_ch.roll_in = '0;
        sample_ch.pitch_in = '0;
        sample_ch.yaw_in = '0;
        sample_ch.accel_x_in = '0;
        sample_ch.accel_y_in = '0;
        sample_ch.accel_z_in = '0;
        sample_ch.sample_tag = '0;
        result_ch.ready = 1'b0;
    end

    // The item stays valid after it is taken; an idle cycle or stop_sending drops it.
    task automatic send_sample(sample_t s);
        while (source_idles && $urandom_range(99) < 21)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.roll_in <= s.roll;
        sample_ch.pitch_in <= s.pitch;
        sample_ch.yaw_in <= s.yaw;
        sample_ch.accel_x_in <= s.ax;
        sample_ch.accel_y_in <= s.ay;
        sample_ch.accel_z_in <= s.az;
        sample_ch.sample_tag <= s.tag;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        pending_rotations.push_back(rotate_sample(s));
    endtask

    task automatic stop_sending();
        sample_ch.valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        rotated_t want;
        cycles <= cycles + 1;
        if (rst_n && result_ch.valid && result_ch.ready) begin
            if (pending_rotations.size() == 0) begin
                $error("unexpected result, tag %h", result_ch.tag_out);
                failures++;
            end else begin
                want = pending_rotations.pop_front();
                if (result_ch.roll_out !== want.roll) begin
                    $error("roll_out expected %0d got %0d", want.roll, result_ch.roll_out);
                    failures++;
                end
                if (result_ch.pitch_out !== want.pitch) begin
                    $error("pitch_out expected %0d got %0d", want.pitch, result_ch.pitch_out);
                    failures++;
                end
                if (result_ch.yaw_out !== want.yaw) begin
                    $error("yaw_out expected %0d got %0d", want.yaw, result_ch.yaw_out);
                    failures++;
                end
                if (result_ch.rotated_x !== want.rx) begin
                    $error("rotated_x expected %0d got %0d", want.rx, result_ch.rotated_x);
                    failures++;
                end
                if (result_ch.rotated_y !== want.ry) begin
                    $error("rotated_y expected %0d got %0d", want.ry, result_ch.rotated_y);
                    failures++;
                end
                if (result_ch.rotated_z !== want.rz) begin
                    $error("rotated_z expected %0d got %0d", want.rz, result_ch.rotated_z);
                    failures++;
                end
                if (result_ch.tag_out !== want.tag) begin
                    $error("tag_out expected %h got %h", want.tag, result_ch.tag_out);
                    failures++;
                end
            end
        end
        result_ch.ready <= !(sink_idles && $urandom_range(99) < 21);
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic test_extremes();
        logic signed [AW-1:0] angles[7];
        logic signed [CW-1:0] accels[5];
        sample_t s;
        angles = '{16'sh7FFF, 16'sh8000, 16'sd0, 16'sd12868, -16'sd12868,
                   16'sd12869, 16'sd25736};
        accels = '{20'sh7FFFF, 20'sh80000, 20'sd0, 20'sd1024, -20'sd1};
        // Right angles, the pi/2 fold points and the field limits.
        for (int i = 0; i < 7; i++)
        begin
            s.roll = angles[i];
            s.pitch = angles[(i + 3) % 7];
            s.yaw = angles[(i + 5) % 7];
            s.ax = accels[i % 5];
            s.ay = accels[(i + 1) % 5];
            s.az = accels[(i + 2) % 5];
            s.tag = (i % 2) ? 32'hFFFF_FFFF : 32'h0;
            send_sample(s);
        end
        // Full-scale acceleration on every axis, in all eight sign combinations.
        for (int i = 0; i < 8; i++)
        begin
            s.roll = angles[i % 7];
            s.pitch = angles[(i + 1) % 7];
            s.yaw = angles[(i + 2) % 7];
            s.ax = (i & 1) ? 20'sh80000 : 20'sh7FFFF;
            s.ay = (i & 2) ? 20'sh80000 : 20'sh7FFFF;
            s.az = (i & 4) ? 20'sh80000 : 20'sh7FFFF;
            s.tag = $urandom;
            send_sample(s);
        end
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_sample(random_sample());
    endtask

    task automatic test_drain_and_resume();
        test_random(40);
        stop_sending();
        wait (pending_rotations.size() == 0);
        @(posedge clk);
        test_random(40);
    endtask

    task automatic test_back_to_back();
        source_idles = 1'b0;
        sink_idles = 1'b0;
        test_random(200);
        source_idles = 1'b1;
        sink_idles = 1'b1;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_random(300);
        test_drain_and_resume();
        test_back_to_back();
        test_random(200);
        stop_sending();
        wait (pending_rotations.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        if (failures == 0 && pending_rotations.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire

[files.f]
+incdir+hdl
hdl/era_pkg.sv
hdl/era_if.sv
hdl/era_cordic.sv
hdl/euler_rotate_acceleration.sv
verif/euler_rotate_acceleration_tb.sv
